[hdl/salc_pkg.sv]
// ----------------------------------------------------------------------------
// salc_pkg
// Shared types, constants and geometry function of the LRU cache predictor.
// ----------------------------------------------------------------------------
package salc_pkg;

    localparam int DEF_MAX_LINES = 1024;
    localparam int DEF_MAX_WAYS  = 16;
    localparam int DEF_ADDR_BITS = 32;

    localparam int OFF_BITS = 5;
    localparam int RANK_W   = 4;
    localparam int CFG_W    = 3;
    localparam int IDX_W    = 2;

    localparam logic [IDX_W-1:0] CFG_SIZE  = 2'd0;
    localparam logic [IDX_W-1:0] CFG_WAYS  = 2'd1;
    localparam logic [IDX_W-1:0] CFG_ALLOC = 2'd2;
    localparam logic [IDX_W-1:0] CFG_PF    = 2'd3;

    localparam logic [1:0] PF_ALL  = 2'd1;
    localparam logic [1:0] PF_MISS = 2'd2;

    typedef struct packed {
        logic [2:0] wl;
        logic [3:0] sb;
    } t_geo;

    typedef enum logic [2:0] {
        ST_CLR,
        ST_IDLE,
        ST_EV1,
        ST_RD2,
        ST_EV2,
        ST_OUT
    } t_state;

    function automatic t_geo calc_geo(logic [2:0] csz, logic [2:0] wys,
                                      int lines_l2, int ways_l2);
        int   csl;
        int   ll;
        int   wl;
        t_geo g;
        csl = (csz > 3'd5) ? 5 : int'(csz);
        ll  = OFF_BITS + csl;
        if (ll > lines_l2 && lines_l2 >= OFF_BITS) ll = lines_l2;
        wl = (wys > 3'd4) ? 4 : int'(wys);
        if (wl > ways_l2) wl = ways_l2;
        if (wl >= ll) wl = ll - 1;
        g.wl = 3'(wl);
        g.sb = 4'(ll - wl);
        return g;
    endfunction

endpackage

[hdl/salc_front.sv]
// ----------------------------------------------------------------------------
// salc_front
// Splits an access into demand and next-line set rows, lane offsets and tags.
// ----------------------------------------------------------------------------
module salc_front #(
    parameter int MAX_LINES = salc_pkg::DEF_MAX_LINES,
    parameter int MAX_WAYS  = salc_pkg::DEF_MAX_WAYS,
    parameter int ADDR_BITS = salc_pkg::DEF_ADDR_BITS,
    parameter int REQ_W     = 8
) (
    input  logic [ADDR_BITS-1:0] i_addr,
    input  logic                 i_load,
    input  salc_pkg::t_geo       i_geo,
    input  logic                 i_alloc_st,
    input  logic [1:0]           i_pf_mode,
    output logic [REQ_W-1:0]     o_req
);
    import salc_pkg::*;

    localparam int LN_W   = ADDR_BITS - OFF_BITS;
    localparam int TAG_W  = ADDR_BITS - OFF_BITS - 1;
    localparam int LIN_W  = $clog2(MAX_LINES);
    localparam int WAY_L2 = $clog2(MAX_WAYS);
    localparam int ROW_W  = LIN_W - WAY_L2;
    localparam int LANE_W = (WAY_L2 > 0) ? WAY_L2 : 1;
    localparam int BW     = LN_W + 16;

    logic [LN_W-1:0]   dem_line, nxt_line, set_mask;
    logic [LIN_W-1:0]  dem_base, nxt_base;
    logic [TAG_W-1:0]  dem_tag, nxt_tag;
    logic [ROW_W-1:0]  dem_row, nxt_row;
    logic [LANE_W-1:0] dem_off, nxt_off;

    assign dem_line = i_addr[ADDR_BITS-1:OFF_BITS];
    assign nxt_line = dem_line + LN_W'(1);
    assign set_mask = ~({LN_W{1'b1}} << i_geo.sb);

    assign dem_tag  = TAG_W'(dem_line >> i_geo.sb);
    assign nxt_tag  = TAG_W'(nxt_line >> i_geo.sb);
    assign dem_base = LIN_W'(BW'(dem_line & set_mask) << i_geo.wl);
    assign nxt_base = LIN_W'(BW'(nxt_line & set_mask) << i_geo.wl);
    assign dem_row  = ROW_W'(dem_base >> WAY_L2);
    assign nxt_row  = ROW_W'(nxt_base >> WAY_L2);
    assign dem_off  = LANE_W'(dem_base & LIN_W'(MAX_WAYS - 1));
    assign nxt_off  = LANE_W'(nxt_base & LIN_W'(MAX_WAYS - 1));

    assign o_req = {i_pf_mode == PF_MISS, i_pf_mode == PF_ALL, i_load | i_alloc_st,
                    nxt_tag, nxt_off, nxt_row, dem_tag, dem_off, dem_row};

endmodule

[hdl/salc_fifo.sv]
// ----------------------------------------------------------------------------
// salc_fifo
// Two-entry queue between the request front end and the lookup engine.
// ----------------------------------------------------------------------------
module salc_fifo #(
    parameter int W = 8
) (
    input  logic         i_clk,
    input  logic         i_rst_n,
    input  logic         i_push,
    input  logic [W-1:0] i_data,
    input  logic         i_pop,
    output logic         o_full,
    output logic         o_valid,
    output logic [W-1:0] o_data
);
    logic [W-1:0] r_mem [2];
    logic         r_wp, r_rp;
    logic [1:0]   r_cnt;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= 1'b0;
            r_rp  <= 1'b0;
            r_cnt <= 2'd0;
        end else begin
            if (i_push) begin
                r_wp <= ~r_wp;
            end
            if (i_pop) begin
                r_rp <= ~r_rp;
            end
            r_cnt <= r_cnt + 2'(i_push) - 2'(i_pop);
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wp] <= i_data;
        end
    end

    assign o_full  = r_cnt == 2'd2;
    assign o_valid = r_cnt != 2'd0;
    assign o_data  = r_mem[r_rp];

endmodule

[hdl/salc_back.sv]
// ----------------------------------------------------------------------------
// salc_back
// Tag, valid and LRU rank store with lookup, allocate and prefetch sequencer.
// ----------------------------------------------------------------------------
module salc_back #(
    parameter int MAX_LINES = salc_pkg::DEF_MAX_LINES,
    parameter int MAX_WAYS  = salc_pkg::DEF_MAX_WAYS,
    parameter int ADDR_BITS = salc_pkg::DEF_ADDR_BITS,
    parameter int REQ_W     = 8
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_flush,
    input  salc_pkg::t_geo   i_geo,
    input  logic             i_req_valid,
    input  logic [REQ_W-1:0] i_req,
    output logic             o_pop,
    output logic             o_clearing,
    output logic             o_valid,
    output logic             o_hit,
    input  logic             i_ready
);
    import salc_pkg::*;

    localparam int TAG_W  = ADDR_BITS - OFF_BITS - 1;
    localparam int LIN_W  = $clog2(MAX_LINES);
    localparam int WAY_L2 = $clog2(MAX_WAYS);
    localparam int ROW_W  = LIN_W - WAY_L2;
    localparam int ROWS   = MAX_LINES / MAX_WAYS;
    localparam int LANE_W = (WAY_L2 > 0) ? WAY_L2 : 1;
    localparam int NR     = 1 << RANK_W;
    localparam int P_DOFF = ROW_W;
    localparam int P_DTAG = P_DOFF + LANE_W;
    localparam int P_NROW = P_DTAG + TAG_W;
    localparam int P_NOFF = P_NROW + ROW_W;
    localparam int P_NTAG = P_NOFF + LANE_W;
    localparam int P_FLG  = P_NTAG + TAG_W;

    logic [MAX_WAYS*TAG_W-1:0]  tag_mem [ROWS];
    logic [MAX_WAYS-1:0]        val_mem [ROWS];
    logic [MAX_WAYS*RANK_W-1:0] rnk_mem [ROWS];

    logic [MAX_WAYS*TAG_W-1:0]  r_rd_tag;
    logic [MAX_WAYS-1:0]        r_rd_val;
    logic [MAX_WAYS*RANK_W-1:0] r_rd_rnk;

    t_state           r_state, n_state;
    logic [REQ_W-1:0] r_req;
    logic             r_hit, n_hit;
    logic [ROW_W-1:0] r_clr;
    logic             r_out_valid, r_out_hit;

    logic                       rd_en, we_meta, we_tag, load_out, out_val;
    logic [ROW_W-1:0]           rd_row, wa;
    logic [MAX_WAYS*TAG_W-1:0]  wd_tag;
    logic [MAX_WAYS-1:0]        wd_val;
    logic [MAX_WAYS*RANK_W-1:0] wd_rnk;

    logic                       second, c_alloc, e_hit, e_upd;
    logic [ROW_W-1:0]           c_row;
    logic [LANE_W-1:0]          c_off;
    logic [TAG_W-1:0]           c_tag;
    logic [MAX_WAYS*TAG_W-1:0]  e_tag;
    logic [MAX_WAYS-1:0]        e_val;
    logic [MAX_WAYS*RANK_W-1:0] e_rnk;
    logic                       pf_go;

    assign second  = r_state == ST_EV2;
    assign c_row   = second ? r_req[P_NOFF-1:P_NROW] : r_req[P_DOFF-1:0];
    assign c_off   = second ? r_req[P_NTAG-1:P_NOFF] : r_req[P_DTAG-1:P_DOFF];
    assign c_tag   = second ? r_req[P_FLG-1:P_NTAG] : r_req[P_NROW-1:P_DTAG];
    assign c_alloc = second | r_req[P_FLG];

    always_comb begin
        logic [LANE_W-1:0] hi_mask;
        logic [MAX_WAYS-1:0] inset, match, free;
        logic [NR-1:0]     has_r;
        logic [RANK_W-1:0] rk, oldest;
        logic [LANE_W-1:0] hit_l, free_l, old_l, w;
        logic              any_free, found_old;
        logic [RANK_W:0]   old_rank;
        hi_mask   = ~LANE_W'((1 << i_geo.wl) - 1);
        has_r     = '0;
        hit_l     = '0;
        free_l    = '0;
        old_l     = '0;
        oldest    = '0;
        found_old = 1'b0;
        for (int l = 0; l < MAX_WAYS; l++) begin
            inset[l] = ((LANE_W'(l) ^ c_off) & hi_mask) == '0;
            match[l] = inset[l] & r_rd_val[l] & (r_rd_tag[l*TAG_W +: TAG_W] == c_tag);
            free[l]  = inset[l] & ~r_rd_val[l];
        end
        for (int l = MAX_WAYS - 1; l >= 0; l--) begin
            if (match[l]) hit_l = LANE_W'(l);
            if (free[l]) free_l = LANE_W'(l);
        end
        for (int r = 0; r < NR; r++) begin
            for (int l = 0; l < MAX_WAYS; l++) begin
                if (inset[l] && r_rd_rnk[l*RANK_W +: RANK_W] == RANK_W'(r)) has_r[r] = 1'b1;
            end
        end
        for (int r = 0; r < NR; r++) begin
            if (has_r[r]) oldest = RANK_W'(r);
        end
        for (int l = 0; l < MAX_WAYS; l++) begin
            if (!found_old && inset[l] && r_rd_rnk[l*RANK_W +: RANK_W] == oldest) begin
                old_l     = LANE_W'(l);
                found_old = 1'b1;
            end
        end
        e_hit    = |match;
        any_free = |free;
        e_upd    = e_hit | c_alloc;
        if (e_hit) begin
            w        = hit_l;
            old_rank = {1'b0, r_rd_rnk[hit_l*RANK_W +: RANK_W]};
        end else if (any_free) begin
            w        = free_l;
            old_rank = (RANK_W+1)'(1 << i_geo.wl);
        end else begin
            w        = old_l;
            old_rank = {1'b0, oldest};
        end
        e_tag = r_rd_tag;
        e_val = r_rd_val;
        e_rnk = r_rd_rnk;
        for (int l = 0; l < MAX_WAYS; l++) begin
            rk = r_rd_rnk[l*RANK_W +: RANK_W];
            if (LANE_W'(l) == w) begin
                e_rnk[l*RANK_W +: RANK_W] = '0;
                e_val[l]                  = 1'b1;
                e_tag[l*TAG_W +: TAG_W]   = c_tag;
            end else if (inset[l] && r_rd_val[l] && {1'b0, rk} < old_rank && rk != '1) begin
                e_rnk[l*RANK_W +: RANK_W] = rk + RANK_W'(1);
            end
        end
    end

    assign pf_go = r_req[P_FLG+1] | (r_req[P_FLG+2] & ~e_hit);

    always_comb begin
        n_state  = r_state;
        n_hit    = r_hit;
        rd_en    = 1'b0;
        rd_row   = i_req[P_DOFF-1:0];
        we_meta  = 1'b0;
        we_tag   = 1'b0;
        wa       = c_row;
        wd_tag   = e_tag;
        wd_val   = e_val;
        wd_rnk   = e_rnk;
        o_pop    = 1'b0;
        load_out = 1'b0;
        out_val  = r_hit;
        case (r_state)
            ST_CLR: begin
                we_meta = 1'b1;
                wa      = r_clr;
                wd_val  = '0;
                wd_rnk  = '0;
                if (r_clr == ROW_W'(ROWS - 1)) n_state = ST_IDLE;
            end
            ST_IDLE: begin
                if (i_req_valid) begin
                    o_pop   = 1'b1;
                    rd_en   = 1'b1;
                    n_state = ST_EV1;
                end
            end
            ST_EV1: begin
                we_meta = e_upd;
                we_tag  = e_upd;
                n_hit   = e_hit;
                out_val = e_hit;
                if (pf_go) begin
                    n_state = ST_RD2;
                end else if (!r_out_valid || i_ready) begin
                    load_out = 1'b1;
                    n_state  = ST_IDLE;
                end else begin
                    n_state = ST_OUT;
                end
            end
            ST_RD2: begin
                rd_en   = 1'b1;
                rd_row  = r_req[P_NOFF-1:P_NROW];
                n_state = ST_EV2;
            end
            ST_EV2: begin
                we_meta = 1'b1;
                we_tag  = 1'b1;
                if (!r_out_valid || i_ready) begin
                    load_out = 1'b1;
                    n_state  = ST_IDLE;
                end else begin
                    n_state = ST_OUT;
                end
            end
            ST_OUT: begin
                if (!r_out_valid || i_ready) begin
                    load_out = 1'b1;
                    n_state  = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_CLR;
            end
        endcase
        if (i_flush) n_state = ST_CLR;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_CLR;
            r_clr       <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            if (i_flush) begin
                r_clr <= '0;
            end else if (r_state == ST_CLR) begin
                r_clr <= r_clr + ROW_W'(1);
            end
            if (load_out) begin
                r_out_valid <= 1'b1;
            end else if (i_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_hit <= n_hit;
        if (o_pop) r_req <= i_req;
        if (load_out) r_out_hit <= out_val;
    end

    always_ff @(posedge i_clk) begin
        if (we_meta) begin
            val_mem[wa] <= wd_val;
            rnk_mem[wa] <= wd_rnk;
        end
        if (we_tag) tag_mem[wa] <= wd_tag;
        if (rd_en) begin
            r_rd_val <= val_mem[rd_row];
            r_rd_rnk <= rnk_mem[rd_row];
            r_rd_tag <= tag_mem[rd_row];
        end
    end

    assign o_clearing = r_state == ST_CLR;
    assign o_valid    = r_out_valid;
    assign o_hit      = r_out_hit;

endmodule

[hdl/set_assoc_lru_cache_hit_predictor.sv]
// ----------------------------------------------------------------------------
// set_assoc_lru_cache_hit_predictor
// LRU set-associative cache hit predictor with next-line prefetch.
//
//   channel | signals                    | word
//   in      | s_axis_tvalid/tready       | tdata: address; tuser: is_load
//   out     | m_axis_tvalid/tready       | tdata: hit in bit 0
//   cfg     | i_cfg_we/i_cfg_idx/data    | one register per write
//
// An access passes through state EV1, or EV1, RD2 and EV2 when a prefetch
// lookup follows; each lookup is a read then a read-modify-write of one row
// of the tag/LRU store. Reset and any geometry write start a clearing pass
// over all MAX_LINES/MAX_WAYS rows (64 by default) with s_axis_tready low.
// A two-word queue decouples accept from lookup; the result register holds
// while m_axis_tready is low.
// ----------------------------------------------------------------------------
module set_assoc_lru_cache_hit_predictor #(
    parameter int MAX_LINES = salc_pkg::DEF_MAX_LINES,
    parameter int MAX_WAYS  = salc_pkg::DEF_MAX_WAYS,
    parameter int ADDR_BITS = salc_pkg::DEF_ADDR_BITS
) (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                s_axis_tvalid,
    output logic                                s_axis_tready,
    input  logic [((ADDR_BITS+7)/8)*8-1:0]      s_axis_tdata,  // address
    input  logic                                s_axis_tuser,  // is_load
    output logic                                m_axis_tvalid,
    input  logic                                m_axis_tready,
    output logic [7:0]                          m_axis_tdata,  // hit
    input  logic                                i_cfg_we,
    input  logic [salc_pkg::IDX_W-1:0]          i_cfg_idx,
    input  logic [salc_pkg::CFG_W-1:0]          i_cfg_data
);
    import salc_pkg::*;

    localparam int TAG_W  = ADDR_BITS - OFF_BITS - 1;
    localparam int LIN_W  = $clog2(MAX_LINES);
    localparam int WAY_L2 = $clog2(MAX_WAYS);
    localparam int ROW_W  = LIN_W - WAY_L2;
    localparam int LANE_W = (WAY_L2 > 0) ? WAY_L2 : 1;
    localparam int REQ_W  = 2 * (ROW_W + LANE_W + TAG_W) + 3;

    logic [2:0]       r_csz, r_wys;
    logic             r_alloc_st;
    logic [1:0]       r_pf;
    logic             flush, push, full, q_valid, pop, clearing, hit;
    logic [REQ_W-1:0] req, q_req;
    t_geo             geo;

    assign geo   = calc_geo(r_csz, r_wys, LIN_W, WAY_L2);
    assign flush = i_cfg_we && (i_cfg_idx == CFG_SIZE || i_cfg_idx == CFG_WAYS);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_csz      <= 3'd4;
            r_wys      <= 3'd1;
            r_alloc_st <= 1'b1;
            r_pf       <= 2'd0;
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                CFG_SIZE:  r_csz      <= i_cfg_data;
                CFG_WAYS:  r_wys      <= i_cfg_data;
                CFG_ALLOC: r_alloc_st <= i_cfg_data[0];
                CFG_PF:    r_pf       <= i_cfg_data[1:0];
                default:   r_pf       <= r_pf;
            endcase
        end
    end

    assign s_axis_tready = ~full & ~clearing;
    assign push          = s_axis_tvalid & s_axis_tready;

    salc_front #(
        .MAX_LINES(MAX_LINES), .MAX_WAYS(MAX_WAYS),
        .ADDR_BITS(ADDR_BITS), .REQ_W(REQ_W)
    ) u_front (
        .i_addr     (s_axis_tdata[ADDR_BITS-1:0]),
        .i_load     (s_axis_tuser),
        .i_geo      (geo),
        .i_alloc_st (r_alloc_st),
        .i_pf_mode  (r_pf),
        .o_req      (req)
    );

    salc_fifo #(.W(REQ_W)) u_fifo (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_data  (req),
        .i_pop   (pop),
        .o_full  (full),
        .o_valid (q_valid),
        .o_data  (q_req)
    );

    salc_back #(
        .MAX_LINES(MAX_LINES), .MAX_WAYS(MAX_WAYS),
        .ADDR_BITS(ADDR_BITS), .REQ_W(REQ_W)
    ) u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_flush     (flush),
        .i_geo       (geo),
        .i_req_valid (q_valid),
        .i_req       (q_req),
        .o_pop       (pop),
        .o_clearing  (clearing),
        .o_valid     (m_axis_tvalid),
        .o_hit       (hit),
        .i_ready     (m_axis_tready)
    );

    assign m_axis_tdata = {7'd0, hit};

endmodule

[hdl/salc_checker.sv]
// ----------------------------------------------------------------------------
// salc_checker
// Port-level checks of the LRU cache predictor, bound to the top level.
// ----------------------------------------------------------------------------
module salc_checker (
    input logic                          i_clk,
    input logic                          i_rst_n,
    input logic                          s_axis_tready,
    input logic                          m_axis_tvalid,
    input logic                          m_axis_tready,
    input logic [7:0]                    m_axis_tdata,
    input logic                          i_cfg_we,
    input logic [salc_pkg::IDX_W-1:0]    i_cfg_idx
);
    import salc_pkg::*;

    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
        else $error("result changed while stalled");

    a_rst_out: assert property (@(posedge i_clk)
        !i_rst_n |=> !m_axis_tvalid)
        else $error("result valid after reset");

    a_rst_clr: assert property (@(posedge i_clk)
        !i_rst_n |=> !s_axis_tready)
        else $error("input ready during clearing after reset");

    a_geo_clr: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cfg_we && (i_cfg_idx == CFG_SIZE || i_cfg_idx == CFG_WAYS) |=> !s_axis_tready)
        else $error("input ready during clearing after geometry write");

    a_pad: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid |-> m_axis_tdata[7:1] == 7'd0)
        else $error("result padding not zero");

endmodule

bind set_assoc_lru_cache_hit_predictor salc_checker u_salc_checker (
    .i_clk         (i_clk),
    .i_rst_n       (i_rst_n),
    .s_axis_tready (s_axis_tready),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .i_cfg_we      (i_cfg_we),
    .i_cfg_idx     (i_cfg_idx)
);
